// ----- hw/rtl/upng_pkg.sv -----
// -----------------------------------------------------------------------------
// upng_pkg
// Types, constants and byte tables shared by the PNG stream encoder.
// -----------------------------------------------------------------------------
package upng_pkg;

    localparam int unsigned DIM_W    = 14;
    localparam int unsigned COL_W    = 13;
    localparam int unsigned DATA_W   = 28;
    localparam int unsigned BLK_W    = 17;
    localparam int unsigned IDX_W    = 6;

    localparam logic [DIM_W-1:0] MAX_DIM   = 14'd8192;
    localparam logic [BLK_W-1:0] BLOCK_LEN = 17'd65535;
    localparam logic [31:0]      CRC_POLY  = 32'hedb88320;
    localparam logic [31:0]      CRC_INIT  = 32'hffffffff;
    localparam logic [16:0]      ADLER_MOD = 17'd65521;

    localparam logic [IDX_W-1:0] ST_IHDR_TYPE = 6'd12;
    localparam logic [IDX_W-1:0] ST_IHDR_END  = 6'd28;
    localparam logic [IDX_W-1:0] ST_IDAT_TYPE = 6'd37;
    localparam logic [IDX_W-1:0] ST_LAST      = 6'd42;
    localparam logic [IDX_W-1:0] TL_ADLER_END = 6'd3;
    localparam logic [IDX_W-1:0] TL_IEND_TYPE = 6'd12;
    localparam logic [IDX_W-1:0] TL_IEND_END  = 6'd15;
    localparam logic [IDX_W-1:0] TL_LAST      = 6'd19;

    localparam logic [1:0] SEL_FILTER = 2'd0;
    localparam logic [1:0] SEL_RED    = 2'd1;
    localparam logic [1:0] SEL_GREEN  = 2'd2;
    localparam logic [1:0] SEL_BLUE   = 2'd3;

    localparam logic [2:0] HDR_LAST = 3'd4;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic KIND_START = 1'b0;

    typedef enum logic [1:0] {
        PH_START,
        PH_PIXEL,
        PH_TAIL
    } t_phase;

    typedef struct packed {
        logic feed_crc;
        logic init_crc;
        logic feed_adler;
        logic init_adler;
    } t_sum_ctl;

    function automatic logic [DIM_W-1:0] f_clamp(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = 14'd1;
        end else if (v > MAX_DIM) begin
            r = MAX_DIM;
        end
        return r;
    endfunction

    function automatic logic [31:0] f_crc8(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
        end
        return r;
    endfunction

    function automatic logic [7:0] f_be_byte(input logic [31:0] v, input logic [1:0] pos);
        logic [7:0] r;
        case (pos)
            2'd0:    r = v[31:24];
            2'd1:    r = v[23:16];
            2'd2:    r = v[15:8];
            default: r = v[7:0];
        endcase
        return r;
    endfunction

    function automatic logic [7:0] f_start_byte(
        input logic [IDX_W-1:0] idx,
        input logic [DIM_W-1:0] w,
        input logic [DIM_W-1:0] h,
        input logic [31:0]      crc,
        input logic [31:0]      idat_len
    );
        logic [7:0] r;
        case (idx)
            6'd0:  r = 8'h89;
            6'd1:  r = 8'h50;
            6'd2:  r = 8'h4e;
            6'd3:  r = 8'h47;
            6'd4:  r = 8'h0d;
            6'd5:  r = 8'h0a;
            6'd6:  r = 8'h1a;
            6'd7:  r = 8'h0a;
            6'd11: r = 8'h0d;
            6'd12: r = 8'h49;
            6'd13: r = 8'h48;
            6'd14: r = 8'h44;
            6'd15: r = 8'h52;
            6'd18: r = {2'd0, w[13:8]};
            6'd19: r = w[7:0];
            6'd22: r = {2'd0, h[13:8]};
            6'd23: r = h[7:0];
            6'd24: r = 8'h08;
            6'd25: r = 8'h02;
            6'd29: r = crc[31:24];
            6'd30: r = crc[23:16];
            6'd31: r = crc[15:8];
            6'd32: r = crc[7:0];
            6'd33: r = idat_len[31:24];
            6'd34: r = idat_len[23:16];
            6'd35: r = idat_len[15:8];
            6'd36: r = idat_len[7:0];
            6'd37: r = 8'h49;
            6'd38: r = 8'h44;
            6'd39: r = 8'h41;
            6'd40: r = 8'h54;
            6'd41: r = 8'h78;
            6'd42: r = 8'h01;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] f_tail_byte(
        input logic [IDX_W-1:0] idx,
        input logic [31:0]      adler,
        input logic [31:0]      crc
    );
        logic [7:0] r;
        case (idx)
            6'd0, 6'd1, 6'd2, 6'd3:     r = f_be_byte(adler, idx[1:0]);
            6'd4, 6'd5, 6'd6, 6'd7,
            6'd16, 6'd17, 6'd18, 6'd19: r = f_be_byte(crc, idx[1:0]);
            6'd12: r = 8'h49;
            6'd13: r = 8'h45;
            6'd14: r = 8'h4e;
            6'd15: r = 8'h44;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ----- hw/rtl/upng_if.sv -----
// -----------------------------------------------------------------------------
// upng_if
// Valid/ready stream interfaces for pixel items and PNG output bytes.
// -----------------------------------------------------------------------------
interface upng_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, kind, red, green, blue, input ready);
    modport sink (input valid, kind, red, green, blue, output ready);
endinterface

interface upng_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       file_done;

    modport source (output valid, out_byte, run_last, file_done, input ready);
    modport sink (input valid, out_byte, run_last, file_done, output ready);
endinterface

// ----- hw/rtl/uncompressed_png_encoder.sv -----
// -----------------------------------------------------------------------------
// uncompressed_png_encoder
// Streams an 8-bit RGB image as a PNG file using zlib stored blocks.
// -----------------------------------------------------------------------------
// Usage:
// Program the image width and height over the APB port while the encoder is
// idle, then send a start beat (kind 0) followed by the pixels in raster order
// (kind 1). The output channel carries one file byte per beat; run_last marks
// the final beat of each input item and file_done marks the last byte of the
// file.
// The output sequencer emits one byte per cycle unless the receiver stalls;
// an item yields 43 bytes for a start beat, 3 or 4 for a pixel, 5 more where
// a stored block begins and 20 more on the last pixel. The first byte of an
// item is produced once the item is held in the sequencer state, and is then
// registered in the output register. The next item is taken in the cycle in
// which the previous item's final byte is registered.
// A pixel sent with no image open is consumed without output. A stalled
// receiver holds the output register and the sequencer in place.
// Reset clears the registers to width and height one, closes any image and
// drops beats in flight; no memory is cleared, so the block is ready at once.
// -----------------------------------------------------------------------------
module uncompressed_png_encoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    upng_in_if.sink       i_pix,
    upng_out_if.source    o_byte,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [upng_pkg::DIM_W-1:0] cfg_width;
    logic [upng_pkg::DIM_W-1:0] cfg_height;
    logic [31:0]                crc;
    logic [15:0]                adler_low;
    logic [15:0]                adler_high;
    upng_pkg::t_sum_ctl         sum_ctl;
    logic [7:0]                 sum_byte;

    upng_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_width  (cfg_width),
        .o_height (cfg_height)
    );

    upng_csum u_csum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (sum_byte),
        .i_ctl        (sum_ctl),
        .o_crc        (crc),
        .o_adler_low  (adler_low),
        .o_adler_high (adler_high)
    );

    upng_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (i_pix),
        .o_byte       (o_byte),
        .i_cfg_width  (cfg_width),
        .i_cfg_height (cfg_height),
        .i_crc        (crc),
        .i_adler_low  (adler_low),
        .i_adler_high (adler_high),
        .o_sum_ctl    (sum_ctl),
        .o_sum_byte   (sum_byte)
    );

endmodule

// ----- hw/rtl/upng_cfg.sv -----
// -----------------------------------------------------------------------------
// upng_cfg
// APB register file holding the image width and height.
// -----------------------------------------------------------------------------
module upng_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [upng_pkg::DIM_W-1:0]    o_width,
    output logic [upng_pkg::DIM_W-1:0]    o_height
);

    logic [upng_pkg::DIM_W-1:0] r_width;
    logic [upng_pkg::DIM_W-1:0] r_height;
    logic                       wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 14'd1;
            r_height <= 14'd1;
        end else if (wr_en) begin
            if (paddr[2] == upng_pkg::REG_WIDTH) begin
                r_width <= pwdata[upng_pkg::DIM_W-1:0];
            end else begin
                r_height <= pwdata[upng_pkg::DIM_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == upng_pkg::REG_WIDTH) begin
            prdata = {18'd0, r_width};
        end else begin
            prdata = {18'd0, r_height};
        end
    end

    assign o_width  = r_width;
    assign o_height = r_height;

endmodule

// ----- hw/rtl/upng_csum.sv -----
// -----------------------------------------------------------------------------
// upng_csum
// Running CRC-32 and Adler-32 over the output stream bytes that the sequencer selects.
// -----------------------------------------------------------------------------
module upng_csum (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [7:0]           i_byte,
    input  upng_pkg::t_sum_ctl   i_ctl,
    output logic [31:0]          o_crc,
    output logic [15:0]          o_adler_low,
    output logic [15:0]          o_adler_high
);

    logic [31:0] r_crc;
    logic [31:0] n_crc;
    logic [15:0] r_adl;
    logic [15:0] n_adl;
    logic [15:0] r_adh;
    logic [15:0] n_adh;
    logic [31:0] crc_base;
    logic [16:0] low_sum;
    logic [15:0] low_new;
    logic [16:0] high_sum;

    always_comb begin
        crc_base = i_ctl.init_crc ? upng_pkg::CRC_INIT : r_crc;
        n_crc    = i_ctl.feed_crc ? upng_pkg::f_crc8(crc_base, i_byte) : crc_base;

        low_sum  = {1'b0, r_adl} + {9'd0, i_byte};
        low_new  = (low_sum >= upng_pkg::ADLER_MOD) ? 16'(low_sum - upng_pkg::ADLER_MOD)
                                                    : low_sum[15:0];
        high_sum = {1'b0, r_adh} + {1'b0, low_new};

        n_adl = r_adl;
        n_adh = r_adh;
        if (i_ctl.init_adler) begin
            n_adl = 16'd1;
            n_adh = 16'd0;
        end else if (i_ctl.feed_adler) begin
            n_adl = low_new;
            n_adh = (high_sum >= upng_pkg::ADLER_MOD) ? 16'(high_sum - upng_pkg::ADLER_MOD)
                                                      : high_sum[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= upng_pkg::CRC_INIT;
            r_adl <= 16'd1;
            r_adh <= 16'd0;
        end else begin
            r_crc <= n_crc;
            r_adl <= n_adl;
            r_adh <= n_adh;
        end
    end

    assign o_crc        = r_crc;
    assign o_adler_low  = r_adl;
    assign o_adler_high = r_adh;

endmodule

// ----- hw/rtl/upng_ctrl.sv -----
// -----------------------------------------------------------------------------
// upng_ctrl
// Byte sequencer: walks the headers, stored blocks, pixel bytes and trailer
// of the PNG stream and drives the registered output beat.
// -----------------------------------------------------------------------------
module upng_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    upng_in_if.sink                       i_pix,
    upng_out_if.source                    o_byte,
    input  logic [upng_pkg::DIM_W-1:0]    i_cfg_width,
    input  logic [upng_pkg::DIM_W-1:0]    i_cfg_height,
    input  logic [31:0]                   i_crc,
    input  logic [15:0]                   i_adler_low,
    input  logic [15:0]                   i_adler_high,
    output upng_pkg::t_sum_ctl            o_sum_ctl,
    output logic [7:0]                    o_sum_byte
);

    upng_pkg::t_phase                r_phase;
    upng_pkg::t_phase                n_phase;
    logic                            r_busy;
    logic                            n_busy;
    logic [upng_pkg::IDX_W-1:0]      r_idx;
    logic [upng_pkg::IDX_W-1:0]      n_idx;
    logic [1:0]                      r_dsel;
    logic [1:0]                      n_dsel;
    logic [2:0]                      r_hidx;
    logic [2:0]                      n_hidx;
    logic [upng_pkg::COL_W-1:0]      r_col;
    logic [upng_pkg::COL_W-1:0]      n_col;
    logic [upng_pkg::BLK_W-1:0]      r_blk;
    logic [upng_pkg::BLK_W-1:0]      n_blk;
    logic [upng_pkg::DATA_W-1:0]     r_dleft;
    logic [upng_pkg::DATA_W-1:0]     n_dleft;
    logic                            r_open;
    logic                            n_open;
    logic [upng_pkg::DIM_W-1:0]      r_cur_w;
    logic [upng_pkg::DIM_W-1:0]      r_cur_h;
    logic [7:0]                      r_red;
    logic [7:0]                      r_grn;
    logic [7:0]                      r_blu;
    logic [upng_pkg::DATA_W-1:0]     r_dtot;
    logic [31:0]                     r_idat;
    logic                            r_ovalid;
    logic [7:0]                      r_obyte;
    logic                            r_olast;
    logic                            r_odone;

    logic                            adv;
    logic                            emit;
    logic                            last;
    logic                            done;
    logic [7:0]                      byte_val;
    logic                            accept;
    upng_pkg::t_sum_ctl              sum_ctl;
    logic [upng_pkg::BLK_W-1:0]      blen;
    logic                            bfinal;
    logic [7:0]                      data_val;
    logic [28:0]                     e_sum;
    logic [12:0]                     e_q;
    logic [16:0]                     s_sum;
    logic [12:0]                     nblk;
    logic [31:0]                     crc_out;
    logic [upng_pkg::COL_W:0]        col_inc;

    assign adv     = !r_ovalid || o_byte.ready;
    assign crc_out = ~i_crc;
    assign bfinal  = (r_dleft <= 28'(upng_pkg::BLOCK_LEN));
    assign blen    = bfinal ? r_dleft[upng_pkg::BLK_W-1:0] : upng_pkg::BLOCK_LEN;
    assign col_inc = {1'b0, r_col} + 14'd1;

    assign e_sum = {1'b0, r_dtot} + 29'(upng_pkg::BLOCK_LEN - 17'd1);
    assign e_q   = e_sum[28:16];
    assign s_sum = {4'd0, e_q} + {1'b0, e_sum[15:0]};
    assign nblk  = e_q + ((s_sum >= upng_pkg::BLOCK_LEN) ? 13'd1 : 13'd0);

    always_comb begin
        case (r_dsel)
            upng_pkg::SEL_FILTER: data_val = 8'h00;
            upng_pkg::SEL_RED:    data_val = r_red;
            upng_pkg::SEL_GREEN:  data_val = r_grn;
            default:              data_val = r_blu;
        endcase
    end

    always_comb begin
        n_phase  = r_phase;
        n_busy   = r_busy;
        n_idx    = r_idx;
        n_dsel   = r_dsel;
        n_hidx   = r_hidx;
        n_col    = r_col;
        n_blk    = r_blk;
        n_dleft  = r_dleft;
        n_open   = r_open;
        emit     = 1'b0;
        last     = 1'b0;
        done     = 1'b0;
        byte_val = 8'h00;
        sum_ctl  = '0;

        if (r_busy && adv) begin
            emit = 1'b1;
            case (r_phase)
                upng_pkg::PH_START: begin
                    byte_val = upng_pkg::f_start_byte(r_idx, r_cur_w, r_cur_h,
                                                      crc_out, r_idat);
                    sum_ctl.feed_crc = (r_idx >= upng_pkg::ST_IHDR_TYPE &&
                                        r_idx <= upng_pkg::ST_IHDR_END) ||
                                       (r_idx >= upng_pkg::ST_IDAT_TYPE);
                    sum_ctl.init_crc = (r_idx == upng_pkg::ST_IHDR_TYPE) ||
                                       (r_idx == upng_pkg::ST_IDAT_TYPE);
                    n_idx = r_idx + 6'd1;
                    if (r_idx == upng_pkg::ST_LAST) begin
                        last               = 1'b1;
                        n_busy             = 1'b0;
                        sum_ctl.init_adler = 1'b1;
                        n_col              = '0;
                        n_blk              = '0;
                        n_dleft            = r_dtot;
                        n_open             = 1'b1;
                    end
                end
                upng_pkg::PH_PIXEL: begin
                    sum_ctl.feed_crc = 1'b1;
                    if (r_blk == '0) begin
                        case (r_hidx)
                            3'd0:    byte_val = {7'd0, bfinal};
                            3'd1:    byte_val = blen[7:0];
                            3'd2:    byte_val = blen[15:8];
                            3'd3:    byte_val = ~blen[7:0];
                            default: byte_val = ~blen[15:8];
                        endcase
                        if (r_hidx == upng_pkg::HDR_LAST) begin
                            n_hidx = '0;
                            n_blk  = blen;
                        end else begin
                            n_hidx = r_hidx + 3'd1;
                        end
                    end else begin
                        byte_val           = data_val;
                        sum_ctl.feed_adler = 1'b1;
                        n_blk              = r_blk - 17'd1;
                        n_dleft            = r_dleft - 28'd1;
                        n_dsel             = r_dsel + 2'd1;
                        if (r_dsel == upng_pkg::SEL_BLUE) begin
                            if (col_inc >= r_cur_w) begin
                                n_col = '0;
                            end else begin
                                n_col = col_inc[upng_pkg::COL_W-1:0];
                            end
                            if (r_dleft == 28'd1) begin
                                n_phase = upng_pkg::PH_TAIL;
                                n_idx   = '0;
                            end else begin
                                last   = 1'b1;
                                n_busy = 1'b0;
                            end
                        end
                    end
                end
                upng_pkg::PH_TAIL: begin
                    byte_val = upng_pkg::f_tail_byte(r_idx, {i_adler_high, i_adler_low},
                                                     crc_out);
                    sum_ctl.feed_crc = (r_idx <= upng_pkg::TL_ADLER_END) ||
                                       (r_idx >= upng_pkg::TL_IEND_TYPE &&
                                        r_idx <= upng_pkg::TL_IEND_END);
                    sum_ctl.init_crc = (r_idx == upng_pkg::TL_IEND_TYPE);
                    n_idx = r_idx + 6'd1;
                    if (r_idx == upng_pkg::TL_LAST) begin
                        last   = 1'b1;
                        done   = 1'b1;
                        n_busy = 1'b0;
                        n_open = 1'b0;
                    end
                end
                default: begin
                    emit   = 1'b0;
                    n_busy = 1'b0;
                end
            endcase
        end

        i_pix.ready = !r_busy || last;
        accept      = i_pix.valid && i_pix.ready;

        if (accept) begin
            if (i_pix.kind == upng_pkg::KIND_START) begin
                n_busy  = 1'b1;
                n_phase = upng_pkg::PH_START;
                n_idx   = '0;
            end else if (n_open) begin
                n_busy  = 1'b1;
                n_phase = upng_pkg::PH_PIXEL;
                n_hidx  = '0;
                n_dsel  = (n_col == '0) ? upng_pkg::SEL_FILTER : upng_pkg::SEL_RED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= upng_pkg::PH_START;
            r_busy   <= 1'b0;
            r_idx    <= '0;
            r_dsel   <= '0;
            r_hidx   <= '0;
            r_col    <= '0;
            r_blk    <= '0;
            r_dleft  <= '0;
            r_open   <= 1'b0;
            r_cur_w  <= 14'd1;
            r_cur_h  <= 14'd1;
            r_ovalid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_busy  <= n_busy;
            r_idx   <= n_idx;
            r_dsel  <= n_dsel;
            r_hidx  <= n_hidx;
            r_col   <= n_col;
            r_blk   <= n_blk;
            r_dleft <= n_dleft;
            r_open  <= n_open;
            if (accept && i_pix.kind == upng_pkg::KIND_START) begin
                r_cur_w <= upng_pkg::f_clamp(i_cfg_width);
                r_cur_h <= upng_pkg::f_clamp(i_cfg_height);
            end
            if (adv) begin
                r_ovalid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_red <= i_pix.red;
            r_grn <= i_pix.green;
            r_blu <= i_pix.blue;
        end
        r_dtot <= 28'(r_cur_h * ({1'b0, r_cur_w} * 15'd3 + 15'd1));
        r_idat <= 32'(r_dtot) + 32'(nblk) * 32'd5 + 32'd6;
        if (adv) begin
            r_obyte <= byte_val;
            r_olast <= last;
            r_odone <= done;
        end
    end

    assign o_byte.valid     = r_ovalid;
    assign o_byte.out_byte  = r_obyte;
    assign o_byte.run_last  = r_olast;
    assign o_byte.file_done = r_odone;
    assign o_sum_ctl        = sum_ctl;
    assign o_sum_byte       = byte_val;

    a_pixel_open : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_phase == upng_pkg::PH_PIXEL) |-> (r_open && r_dleft != '0))
        else $error("Pixel bytes are sequenced with no image data left.");

    a_block_len : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blk <= upng_pkg::BLOCK_LEN)
        else $error("Stored block count exceeds the block length.");

    a_done_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_odone) |-> (r_olast && !r_open))
        else $error("File end beat is not the last beat of its item.");

    a_block_in_data : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> ({11'd0, r_blk} <= r_dleft))
        else $error("Stored block runs past the end of the image data.");

endmodule
